[rtl/core/gbfp_pkg.sv]
// Shared types and constants for the GPS binary frame parser.
package gbfp_pkg;

	// Frame marker bytes
	localparam logic [7:0] SYNC0_BYTE = 8'hA0;
	localparam logic [7:0] SYNC1_BYTE = 8'hA2;
	localparam logic [7:0] END0_BYTE  = 8'hB0;
	localparam logic [7:0] END1_BYTE  = 8'hB3;

	// Checksum covers the low 15 bits of the running sum
	localparam logic [15:0] CKSUM_MASK = 16'h7FFF;

	// Register reset values
	localparam logic [7:0] WANTED_ID_RST  = 8'h29;
	localparam logic [7:0] WANTED_LEN_RST = 8'd91;

	// Configuration register indexes
	localparam logic CFG_WANTED_ID  = 1'b0;
	localparam logic CFG_WANTED_LEN = 1'b1;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SYNC1  = 3'd1,
		PH_LENHI  = 3'd2,
		PH_LENLO  = 3'd3,
		PH_WANTED = 3'd4,
		PH_SKIP   = 3'd5,
		PH_END1   = 3'd6,
		PH_ID     = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] wanted_id;
		logic [7:0] wanted_len;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] byte_offset;
		logic [7:0] data_byte;
	} result_t;

endpackage

[rtl/core/gps_binary_frame_parser_unit.sv]
// Top level of the GPS binary frame parser: ports, registers, result register.
//
// Takes one received byte per word on s_axis and looks for frames of the form
// A0 A2, 16-bit big-endian length, message id, payload, 16-bit checksum, B0 B3.
// For the configured id and length each payload byte is sent out on m_axis
// with its offset after the id (tuser = 0); a frame whose 15-bit sum matches
// the sent checksum ends with a completion word (tuser = 1, tdata = 0). Other
// ids are skipped by count, bad markers drop back to hunting for A0.
// Rate: one byte per clock. A byte is taken whenever the result register is
// empty or is being drained in the same cycle; its result, if any, shows on
// m_axis in the next cycle. The single result register sets this figure.
// Registers (cfg port, always ready): index 0 wanted message id (reset 0x29),
// index 1 wanted length (reset 91). Write only while the block is idle.
module gps_binary_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] byte_offset, [15:8] data_byte
	output logic        m_axis_tuser,   // [0] kind
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import gbfp_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	logic    in_accept;

	// Result register
	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_offset_q;
	logic [7:0] out_data_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign in_accept     = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_id  <= WANTED_ID_RST;
			cfg_q.wanted_len <= WANTED_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WANTED_ID:  cfg_q.wanted_id  <= cfg_data;
				CFG_WANTED_LEN: cfg_q.wanted_len <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	gbfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_accept),
		.rx_byte (s_axis_tdata),
		.cfg     (cfg_q),
		.res     (res)
	);

	// valid flag; the payload loads only with an accepted byte that makes a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res.valid) begin
			out_kind_q   <= res.kind;
			out_offset_q <= res.byte_offset;
			out_data_q   <= res.data_byte;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {out_data_q, out_offset_q};

endmodule

[rtl/core/gbfp_parse.sv]
// Frame parser state and per-byte next-state/result logic.
module gbfp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       rx_byte,
	input  gbfp_pkg::cfg_t   cfg,
	output gbfp_pkg::result_t res
);
	import gbfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [7:0]  store_pos_q, store_pos_d;
	logic [15:0] sum_q, sum_d;
	logic        sum_invalid_q, sum_invalid_d;
	logic [15:0] sent_cksum_q, sent_cksum_d;

	logic        count_live;
	logic [15:0] len_plus1;

	assign count_live = ~bytes_left_q[15] & (|bytes_left_q);
	assign len_plus1  = {8'h00, cfg.wanted_len} + 16'd1;

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		store_pos_d   = store_pos_q;
		sum_d         = sum_q;
		sum_invalid_d = sum_invalid_q;
		sent_cksum_d  = sent_cksum_q;
		res           = '0;
		case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == SYNC1_BYTE) begin
					store_pos_d = 8'd0;
					phase_d     = PH_LENHI;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_LENHI: begin
				bytes_left_d = {rx_byte, 8'h00};
				phase_d      = PH_LENLO;
			end
			PH_LENLO: begin
				bytes_left_d = {bytes_left_q[15:8], rx_byte} + 16'd1;
				phase_d      = PH_ID;
			end
			PH_ID: begin
				if (rx_byte == cfg.wanted_id) begin
					if (bytes_left_q == len_plus1) begin
						sum_d         = {8'h00, rx_byte};
						sum_invalid_d = 1'b0;
						phase_d       = PH_WANTED;
					end else begin
						sum_invalid_d = 1'b1;
						phase_d       = PH_IDLE;
					end
				end else begin
					sum_invalid_d = 1'b1;
					phase_d       = PH_SKIP;
				end
			end
			PH_WANTED, PH_SKIP: begin
				if (count_live) begin
					if (phase_q == PH_WANTED) begin
						if (bytes_left_q > 16'd2) begin
							sum_d           = sum_q + {8'h00, rx_byte};
							res.valid       = 1'b1;
							res.kind        = KIND_DATA;
							res.byte_offset = store_pos_q;
							res.data_byte   = rx_byte;
							store_pos_d     = store_pos_q + 8'd1;
						end else if (bytes_left_q == 16'd2) begin
							sent_cksum_d = {rx_byte, sent_cksum_q[7:0]};
						end else begin
							sent_cksum_d = {sent_cksum_q[15:8], rx_byte};
						end
					end
					bytes_left_d = bytes_left_q - 16'd1;
				end else begin
					phase_d = (rx_byte == END0_BYTE) ? PH_END1 : PH_IDLE;
				end
			end
			PH_END1: begin
				if (rx_byte == END1_BYTE && !sum_invalid_q &&
					sent_cksum_q == (sum_q & CKSUM_MASK)) begin
					res.valid = 1'b1;
					res.kind  = KIND_DONE;
				end
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = (rx_byte == SYNC0_BYTE) ? PH_SYNC1 : PH_IDLE;
			end
		endcase
		if (!in_valid) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bytes_left_q  <= '0;
			store_pos_q   <= '0;
			sum_q         <= '0;
			sum_invalid_q <= 1'b0;
			sent_cksum_q  <= '0;
		end else if (in_valid) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			store_pos_q   <= store_pos_d;
			sum_q         <= sum_d;
			sum_invalid_q <= sum_invalid_d;
			sent_cksum_q  <= sent_cksum_d;
		end
	end

	// Completion only leaves the end-marker phase
	a_done_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_DONE) |-> (phase_q == PH_END1))
		else $error("completion outside end phase");

	// Data bytes only come from a wanted frame with bytes still counted
	a_data_from_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_DATA) |-> (phase_q == PH_WANTED && count_live))
		else $error("data byte outside wanted payload");

	// Each data byte advances the offset by one
	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_DATA) |=> (store_pos_q == $past(store_pos_q) + 8'd1))
		else $error("payload offset did not advance");

	// A wanted frame is only entered with a clean sum
	a_wanted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && phase_q == PH_ID && phase_d == PH_WANTED) |=> !sum_invalid_q)
		else $error("wanted frame entered with invalid sum");

endmodule

[tb/sv/gbfp_frame_monitor.sv]
// Frame monitor: predicts the parser's output words from the byte stream and checks them.
`timescale 1ns / 1ps

module gbfp_frame_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [7:0]  s_data,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [15:0] m_data,   // [7:0] byte_offset, [15:8] data_byte
	input  logic        m_user,   // [0] kind
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          data_words,
	output int          done_words
);
	import gbfp_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] offset;
		logic [7:0] data;
	} out_word_t;

	out_word_t pending_words[$];

	// shadow of the parser
	logic [7:0]  want_id;
	logic [7:0]  want_len;
	phase_t      phase;
	logic [15:0] count_left;
	logic [7:0]  next_offset;
	logic [15:0] byte_sum;
	logic        frame_bad;
	logic [15:0] sent_sum;

	// advance the shadow by one received byte; returns 1 when a word is due
	function automatic bit parse_rx_byte(input logic [7:0] b, output out_word_t w);
		bit hit;
		hit = 1'b0;
		w = '0;
		case (phase)
			PH_SYNC1: begin
				if (b == SYNC1_BYTE) begin
					next_offset = 8'd0;
					phase = PH_LENHI;
				end else begin
					phase = PH_IDLE;
				end
			end
			PH_LENHI: begin
				count_left = {b, 8'h00};
				phase = PH_LENLO;
			end
			PH_LENLO: begin
				count_left = {count_left[15:8], b} + 16'd1;
				phase = PH_ID;
			end
			PH_ID: begin
				if (b == want_id) begin
					if (count_left == {8'h00, want_len} + 16'd1) begin
						byte_sum = {8'h00, b};
						frame_bad = 1'b0;
						phase = PH_WANTED;
					end else begin
						frame_bad = 1'b1;
						phase = PH_IDLE;
					end
				end else begin
					frame_bad = 1'b1;
					phase = PH_SKIP;
				end
			end
			PH_WANTED, PH_SKIP: begin
				// count read as signed: zero or negative means nothing to skip
				if (count_left != 16'd0 && !count_left[15]) begin
					if (phase == PH_WANTED) begin
						if (count_left > 16'd2) begin
							byte_sum = byte_sum + {8'h00, b};
							w.kind = KIND_DATA;
							w.offset = next_offset;
							w.data = b;
							hit = 1'b1;
							next_offset = next_offset + 8'd1;
						end else if (count_left == 16'd2) begin
							sent_sum[15:8] = b;
						end else begin
							sent_sum[7:0] = b;
						end
					end
					count_left = count_left - 16'd1;
				end else begin
					phase = (b == END0_BYTE) ? PH_END1 : PH_IDLE;
				end
			end
			PH_END1: begin
				// top bit of the sent sum is compared too, so it never matches when set
				if (b == END1_BYTE && !frame_bad &&
					sent_sum == (byte_sum & CKSUM_MASK)) begin
					w.kind = KIND_DONE;
					hit = 1'b1;
				end
				phase = PH_IDLE;
			end
			default: begin
				phase = (b == SYNC0_BYTE) ? PH_SYNC1 : PH_IDLE;
			end
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		out_word_t got;
		if (!arst_n) begin
			want_id     = WANTED_ID_RST;
			want_len    = WANTED_LEN_RST;
			phase       = PH_IDLE;
			count_left  = '0;
			next_offset = '0;
			byte_sum    = '0;
			frame_bad   = 1'b0;
			sent_sum    = '0;
			pending_words.delete();
			outstanding = 0;
			mismatches  = 0;
			data_words  = 0;
			done_words  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WANTED_ID)
					want_id = cfg_data;
				else
					want_len = cfg_data;
			end
			// output side first: a word leaving now stems from an earlier byte
			if (m_valid && m_ready) begin
				got.kind = m_user;
				got.offset = m_data[7:0];
				got.data = m_data[15:8];
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word kind %0d offset %0d data %02h",
							$realtime, got.kind, got.offset, got.data);
				end else begin
					w = pending_words.pop_front();
					if (got !== w) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: expected kind %0d offset %0d data %02h,",
								" got kind %0d offset %0d data %02h"}, $realtime,
								w.kind, w.offset, w.data, got.kind, got.offset, got.data);
					end
					if (w.kind == KIND_DONE)
						done_words++;
					else
						data_words++;
				end
			end
			if (s_valid && s_ready) begin
				if (parse_rx_byte(s_data, w))
					pending_words.push_back(w);
			end
			outstanding = pending_words.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top: byte stimulus, random back-pressure, register writes and verdict.
`timescale 1ns / 1ps

module tb;
	import gbfp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [7:0]  s_data = 8'h00;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [15:0] m_data;   // [7:0] byte_offset, [15:8] data_byte
	logic        m_user;   // [0] kind
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_WANTED_ID;
	logic [7:0]  cfg_data = 8'h00;

	int mismatches;
	int outstanding;
	int data_words;
	int done_words;

	// stimulus bookkeeping: what was last written, how many bytes went in
	logic [7:0] want_id = WANTED_ID_RST;
	logic [7:0] want_len = WANTED_LEN_RST;
	int         sent_bytes = 0;
	int         settings = 0;
	bit         steady = 1'b0;   // no gaps on either side while set

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gps_binary_frame_parser_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	gbfp_frame_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_valid     (s_valid),
		.s_ready     (s_ready),
		.s_data      (s_data),
		.m_valid     (m_valid),
		.m_ready     (m_ready),
		.m_data      (m_data),
		.m_user      (m_user),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.data_words  (data_words),
		.done_words  (done_words)
	);

	// Result side: random stall before each word, none while steady is set.
	// Handshake is sampled at the falling edge, where everything is settled,
	// and the word counts as taken at the following rising edge.
	initial begin
		int stall;
		bit taken;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = m_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	// One byte word; valid stays high into the next word when no gap is drawn.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		bit taken;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= b;
		do begin
			@(negedge clk);
			taken = s_ready;
			@(posedge clk);
		end while (!taken);
		sent_bytes++;
	endtask

	// Hold off the sender until every predicted word has come out.
	task automatic wait_empty();
		s_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Register write; only called once the parser has gone quiet.
	task automatic write_reg(input logic idx, input logic [7:0] v);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_WANTED_ID)
			want_id = v;
		else
			want_len = v;
	endtask

	task automatic apply_setting(input logic [7:0] id, input logic [7:0] len);
		wait_empty();
		// margin only: bytes that make no word leave nothing in the result stage
		repeat (4) @(posedge clk);
		write_reg(CFG_WANTED_ID, id);
		write_reg(CFG_WANTED_LEN, len);
		settings++;
	endtask

	// Whole frame. flaw: 0 clean, 1 bad checksum, 2 bad first end marker,
	// 3 bad second end marker. Wanted id with a wrong length stops after the id,
	// since the parser drops back to hunting right there.
	task automatic send_frame(input logic [7:0] id, input logic [15:0] len, input int flaw);
		logic [15:0] sum;
		logic [15:0] cksum;
		logic [15:0] skip;
		logic [7:0]  b;
		int          n;
		send_byte(SYNC0_BYTE);
		send_byte(SYNC1_BYTE);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(id);
		skip = len + 16'd1;
		if (id == want_id && len == {8'h00, want_len}) begin
			sum = {8'h00, id};
			for (n = 0; n < int'(len) - 1; n++) begin
				b = 8'($urandom);
				sum = sum + {8'h00, b};
				send_byte(b);
			end
			cksum = sum & CKSUM_MASK;
			if (flaw == 1)
				cksum = $urandom_range(0, 1) ? (cksum | 16'h8000)
					: (cksum ^ (16'h0001 << $urandom_range(0, 14)));
			send_byte(cksum[15:8]);
			send_byte(cksum[7:0]);
		end else if (id != want_id) begin
			// skip count is signed: zero or negative skips nothing
			if (!skip[15])
				for (n = 0; n < int'(skip); n++)
					send_byte(8'($urandom));
		end else begin
			return;
		end
		b = END0_BYTE;
		if (flaw == 2)
			do b = 8'($urandom); while (b == END0_BYTE);
		send_byte(b);
		b = END1_BYTE;
		if (flaw == 3)
			do b = 8'($urandom); while (b == END1_BYTE);
		send_byte(b);
	endtask

	// Directed opening: bad sync (stray byte, A0 A0, lone A2), a one-byte
	// wanted frame at the extremes, wanted id with the wrong length, and an
	// other-id frame whose length wraps the skip count to zero.
	localparam logic [7:0] OPENING [26] = '{
		8'hFF, SYNC0_BYTE, SYNC0_BYTE, SYNC1_BYTE,
		SYNC0_BYTE, SYNC1_BYTE, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'hFF,
		END0_BYTE, END1_BYTE,
		SYNC0_BYTE, SYNC1_BYTE, 8'h00, 8'h03, 8'h00,
		SYNC0_BYTE, SYNC1_BYTE, 8'hFF, 8'hFF, 8'h55, END0_BYTE, END1_BYTE
	};

	initial begin
		int          ph;
		int          budget;
		int          start;
		int          pick;
		int          n;
		bit          paused;
		logic [7:0]  id;
		logic [7:0]  len;
		logic [15:0] flen;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(8'h00, 8'd2);
		foreach (OPENING[i])
			send_byte(OPENING[i]);

		// Random part: eight settings, extremes first and last.
		for (ph = 0; ph < 8; ph++) begin
			steady = (ph == 2 || ph == 5);
			if (ph == 0) begin
				id = 8'h00;
				len = 8'd2;
			end else if (ph == 7) begin
				id = 8'hFF;
				len = 8'd255;
			end else begin
				id = 8'($urandom);
				len = 8'($urandom_range(2, 20));
			end
			apply_setting(id, len);
			budget = (ph == 7) ? 400 : 140;
			start = sent_bytes;
			paused = 1'b0;
			while (sent_bytes - start < budget) begin
				if (!paused && sent_bytes - start >= budget / 2) begin
					wait_empty();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_frame(want_id, {8'h00, want_len}, 0);
				end else if (pick < 65) begin
					send_frame(want_id, {8'h00, want_len}, $urandom_range(1, 3));
				end else if (pick < 80) begin
					do id = 8'($urandom); while (id == want_id);
					case ($urandom_range(0, 11))
						0: flen = 16'h7FFF;
						1: flen = 16'h8000;
						2: flen = 16'hFFFE;
						3: flen = 16'hFFFF;
						default: flen = 16'($urandom_range(0, 30));
					endcase
					send_frame(id, flen, $urandom_range(0, 3));
				end else if (pick < 90) begin
					case ($urandom_range(0, 2))
						0: flen = {8'h00, want_len - 8'd1};
						1: flen = {8'h00, want_len} + 16'd1;
						default: flen = {8'h01, want_len};
					endcase
					send_frame(want_id, flen, 0);
				end else begin
					// line noise, rich in first sync bytes
					for (n = $urandom_range(1, 6); n > 0; n--)
						send_byte($urandom_range(0, 3) == 0 ? SYNC0_BYTE : 8'($urandom));
				end
			end
		end

		wait_empty();
		repeat (10) @(posedge clk);
		$display("%0d bytes over %0d register settings;", sent_bytes, settings);
		$display("%0d payload words and %0d frame ends checked", data_words, done_words);
		if (mismatches == 0 && outstanding == 0) begin
			$display("gps_binary_frame_parser_unit: match");
		end else begin
			$display("gps_binary_frame_parser_unit: mismatch");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3ms;
		$display("gps_binary_frame_parser_unit: mismatch");
		$finish;
	end

endmodule
